[hw/rtl/asd_pkg.sv]
// ----------------------------------------------------------------------------
// asd_pkg
// shared types and constants for the attribute shadow with dirty flush
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int unsigned TableBytes = 64;
  localparam int unsigned OffW       = $clog2(TableBytes);
  localparam int unsigned VAddrW     = 14;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ColorW     = 2;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;

  localparam logic [VAddrW-1:0] ResetBase = 14'h23C0;

  // register index taken from paddr[2]
  localparam logic [0:0] RegBaseAddress = 1'b0;

  typedef enum logic [1:0] {
    KindSet   = 2'd0,
    KindFlush = 2'd1,
    KindFill  = 2'd2
  } kind_e;

  typedef struct packed {
    logic            en;
    logic [OffW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             en;
    logic [OffW-1:0]  addr;
    logic [ByteW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ColorW-1:0] color;
  } mem_fill_t;

endpackage

[hw/rtl/asd_shadow.sv]
// ----------------------------------------------------------------------------
// asd_shadow
// shadow byte memory with written-since-fill flags and fill colour
// ----------------------------------------------------------------------------
module asd_shadow import asd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_rd_t          rd_i,
  input  mem_wr_t          wr_i,
  input  mem_fill_t        fill_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0]      mem_q [TableBytes];
  logic [ByteW-1:0]      rd_raw_q;
  logic                  rd_written_q;
  logic [TableBytes-1:0] written_q;
  logic [ColorW-1:0]     fill_col_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_raw_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
      fill_col_q   <= '0;
    end else begin
      if (rd_i.en) begin
        rd_written_q <= written_q[rd_i.addr];
      end
      if (fill_i.en) begin
        written_q  <= '0;
        fill_col_q <= fill_i.color;
      end else if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // an entry untouched since the last fill reads as the fill pattern
  assign rd_data_o = rd_written_q ? rd_raw_q : {(ByteW/ColorW){fill_col_q}};

endmodule

[hw/rtl/attribute_shadow_dirty_flush_top.sv]
// ----------------------------------------------------------------------------
// attribute_shadow_dirty_flush_top
// attribute table shadow: set, fill and dirty-byte flush with video addresses
// ----------------------------------------------------------------------------
// set: memory read, then merge and write back; fill: applied when accepted
// flush: scans one byte offset per cycle from 0 up to the last dirty byte,
//   one beat per dirty byte, read from the shadow and then registered on the
//   output; output stalls hold the scan, bounded by the single memory read port
// reset clears dirty bits, shadow (reads as zero) and sets base to 0x23C0
// ----------------------------------------------------------------------------
module attribute_shadow_dirty_flush_top import asd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [ColorW-1:0]   color_i,
  input  logic [4:0]          tile_x_i,
  input  logic [4:0]          tile_y_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VAddrW-1:0]   vram_address_o,
  output logic [ByteW-1:0]    byte_value_o,
  output logic                run_start_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSetWr = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [VAddrW-1:0]     base_q;
  logic [TableBytes-1:0] dirty_q;
  logic [OffW-1:0]       set_off_q;
  logic [1:0]            set_quad_q;
  logic [ColorW-1:0]     set_col_q;
  logic [OffW-1:0]       ptr_q;
  logic                  prev_q;
  logic                  rd_v_q;
  logic [VAddrW-1:0]     m_addr_q;
  logic                  m_start_q;
  logic                  m_last_q;
  logic                  out_v_q;
  logic [VAddrW-1:0]     out_addr_q;
  logic [ByteW-1:0]      out_byte_q;
  logic                  out_start_q;
  logic                  out_last_q;

  logic             in_acc;
  logic             cfg_wr;
  logic [OffW-1:0]  in_off;
  logic             out_free;
  logic             rd_move;
  logic             cur_dirty;
  logic             any_other;
  logic             scan;
  logic             issue;
  logic             advance;
  logic [ByteW-1:0] rd_data;
  logic [ByteW-1:0] merged;
  mem_rd_t          mem_rd;
  mem_wr_t          mem_wr;
  mem_fill_t        mem_fill;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegBaseAddress) ?
                  {{(ApbDataW-VAddrW){1'b0}}, base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ResetBase;
    end else if (cfg_wr && paddr[2] == RegBaseAddress) begin
      base_q <= pwdata[VAddrW-1:0];
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_off     = {tile_y_i[4:2], tile_x_i[4:2]};

  assign out_free  = ~out_v_q | ~out_stall_i;
  assign rd_move   = rd_v_q & out_free;
  assign cur_dirty = dirty_q[ptr_q];
  // bytes below the pointer are already clean, so this says whether more follow
  assign any_other = |(dirty_q & ~({{(TableBytes-1){1'b0}}, 1'b1} << ptr_q));
  assign scan      = (state_q == StFlush) && (dirty_q != '0);
  assign issue     = scan & cur_dirty & (~rd_v_q | out_free);
  assign advance   = scan & (~cur_dirty | issue);

  assign mem_rd.en      = (in_acc && kind_i == KindSet) || issue;
  assign mem_rd.addr    = issue ? ptr_q : in_off;
  assign mem_wr.en      = (state_q == StSetWr);
  assign mem_wr.addr    = set_off_q;
  assign mem_wr.data    = merged;
  assign mem_fill.en    = in_acc && kind_i == KindFill;
  assign mem_fill.color = color_i;

  always_comb begin
    merged = rd_data;
    merged[{set_quad_q, 1'b0} +: ColorW] = set_col_q;
  end

  asd_shadow u_shadow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (mem_rd),
    .wr_i      (mem_wr),
    .fill_i    (mem_fill),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && kind_i == KindSet) begin
          state_d = StSetWr;
        end else if (in_acc && kind_i == KindFlush) begin
          state_d = StFlush;
        end
      end
      StSetWr: state_d = StIdle;
      StFlush: begin
        if (dirty_q == '0 && !rd_v_q) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dirty_q <= '0;
      ptr_q   <= '0;
      prev_q  <= 1'b0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_fill.en) begin
        dirty_q <= '0;
      end else begin
        if (state_q == StSetWr) begin
          dirty_q[set_off_q] <= 1'b1;
        end
        if (issue) begin
          dirty_q[ptr_q] <= 1'b0;
        end
      end
      if (in_acc && kind_i == KindFlush) begin
        ptr_q  <= '0;
        prev_q <= 1'b0;
      end else if (advance) begin
        ptr_q  <= ptr_q + 1'b1;
        prev_q <= cur_dirty;
      end
      if (issue) begin
        rd_v_q <= 1'b1;
      end else if (rd_move) begin
        rd_v_q <= 1'b0;
      end
      if (rd_move) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == KindSet) begin
      set_off_q  <= in_off;
      set_quad_q <= {tile_y_i[1], tile_x_i[1]};
      set_col_q  <= color_i;
    end
    if (issue) begin
      m_addr_q  <= base_q + VAddrW'(ptr_q);
      m_start_q <= ~prev_q;
      m_last_q  <= ~any_other;
    end
    if (rd_move) begin
      out_addr_q  <= m_addr_q;
      out_byte_q  <= rd_data;
      out_start_q <= m_start_q;
      out_last_q  <= m_last_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign vram_address_o = out_addr_q;
  assign byte_value_o   = out_byte_q;
  assign run_start_o    = out_start_q;
  assign last_o         = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_rd_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> state_q == StFlush)
    else $error("flush read pending outside flush");

  a_fill_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KindFill) |=> dirty_q == '0)
    else $error("fill left dirty bytes");

  a_set_one_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSetWr |=> state_q == StIdle && dirty_q[$past(set_off_q)])
    else $error("set write-back did not mark byte dirty");

  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush && dirty_q == '0 && !rd_v_q) |=> !in_stall_o)
    else $error("flush did not finish when clean");

endmodule

[verif/tb_attribute_shadow_dirty_flush_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_attribute_shadow_dirty_flush_top
// self-checking bench for the attribute shadow: set, fill and dirty flush
// items are driven with random gaps while a behavioural copy of the shadow
// table predicts every flushed beat, checked field by field on the output
// ----------------------------------------------------------------------------
module tb_attribute_shadow_dirty_flush_top;
  import asd_pkg::*;

  localparam int unsigned ItemTarget  = 410;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned MaxReported = 10;

  localparam logic [1:0]          KindUnused  = 2'd3;
  localparam logic [ByteW-1:0]    ColorMask   = 8'h03;
  localparam logic [ApbAddrW-1:0] BaseRegAddr = {RegBaseAddress, 2'b00};

  typedef struct packed {
    logic [VAddrW-1:0] vaddr;
    logic [ByteW-1:0]  value;
    logic              run_start;
    logic              is_last;
  } beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          kind_i;
  logic [ColorW-1:0]   color_i;
  logic [4:0]          tile_x_i;
  logic [4:0]          tile_y_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [VAddrW-1:0]   vram_address_o;
  logic [ByteW-1:0]    byte_value_o;
  logic                run_start_o;
  logic                last_o;

  // shadow copy of the table and the expected flush beats
  logic [ByteW-1:0]  shadow_bytes [TableBytes];
  logic [TableBytes-1:0] dirty_bytes;
  logic [VAddrW-1:0] vram_base;
  beat_t             pending_beats [$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned hold_len;
  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        draw_stall;
  logic        long_hold;

  assign out_stall_i = draw_stall | long_hold;

  attribute_shadow_dirty_flush_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .color_i        (color_i),
    .tile_x_i       (tile_x_i),
    .tile_y_i       (tile_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vram_address_o (vram_address_o),
    .byte_value_o   (byte_value_o),
    .run_start_o    (run_start_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    end
  endtask

  // advance the shadow copy by one accepted item
  task automatic update_shadow_model(input logic [1:0] kind, input logic [ColorW-1:0] color,
                                     input logic [4:0] tx, input logic [4:0] ty);
    logic [OffW-1:0] off;
    logic [2:0]      shift;
    int              last_dirty;
    logic            prev_dirty;
    beat_t           beat;
    case (kind)
      KindSet: begin
        off   = {ty[4:2], tx[4:2]};
        shift = {ty[1], tx[1], 1'b0};
        shadow_bytes[off] = (shadow_bytes[off] & ~(ColorMask << shift))
                            | (ByteW'(color) << shift);
        dirty_bytes[off] = 1'b1;
      end
      KindFlush: begin
        last_dirty = -1;
        for (int i = 0; i < TableBytes; i++) begin
          if (dirty_bytes[i]) last_dirty = i;
        end
        prev_dirty = 1'b0;
        for (int i = 0; i < TableBytes; i++) begin
          if (dirty_bytes[i]) begin
            beat.vaddr     = vram_base + VAddrW'(i);
            beat.value     = shadow_bytes[i];
            beat.run_start = !prev_dirty;
            beat.is_last   = (i == last_dirty);
            pending_beats.push_back(beat);
          end
          prev_dirty = dirty_bytes[i];
        end
        dirty_bytes = '0;
      end
      KindFill: begin
        for (int i = 0; i < TableBytes; i++) shadow_bytes[i] = {4{color}};
        dirty_bytes = '0;
      end
      default: begin
        // unused kind leaves everything untouched
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [ColorW-1:0] color,
                           input logic [4:0] tx, input logic [4:0] ty);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    color_i    <= color;
    tile_x_i   <= tx;
    tile_y_i   <= ty;
    do @(posedge clk_i); while (in_stall_o);
    update_shadow_model(kind, color, tx, ty);
    if (kind != KindUnused) items_sent++;
  endtask

  // set any quadrant of the byte at a given offset
  task automatic set_byte(input logic [OffW-1:0] off, input logic [ColorW-1:0] color);
    send_item(KindSet, color, {off[2:0], 2'($urandom)}, {off[5:3], 2'($urandom)});
  endtask

  task automatic send_flush();
    send_item(KindFlush, 2'($urandom), 5'($urandom), 5'($urandom));
  endtask

  // drain all beats, then give a flush without results time to finish its scan
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [VAddrW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BaseRegAddr;
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vram_base = value;
    // read back in a second transfer
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[VAddrW-1:0] !== value) flag_mismatch("base readback", 32'(value), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: random stall before each beat
  initial begin : receiver
    int unsigned wait_n;
    draw_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_n = rx_idle_on ? $urandom_range(0, 16) : 0;
      repeat (wait_n) begin
        @(negedge clk_i);
        draw_stall <= 1'b1;
      end
      @(negedge clk_i);
      draw_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // long hold-off on the output, counted in cycles
  initial begin : receiver_hold
    long_hold = 1'b0;
    forever begin
      wait (hold_len != 0);
      @(negedge clk_i);
      long_hold <= 1'b1;
      repeat (hold_len) @(negedge clk_i);
      long_hold <= 1'b0;
      hold_len = 0;
    end
  end

  always @(posedge clk_i) begin : check_beats
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch("beat with none expected", '0, 32'(vram_address_o));
      end else begin
        want = pending_beats.pop_front();
        if (vram_address_o !== want.vaddr) flag_mismatch("vram_address", 32'(want.vaddr),
                                                          32'(vram_address_o));
        if (byte_value_o !== want.value) flag_mismatch("byte_value", 32'(want.value),
                                                        32'(byte_value_o));
        if (run_start_o !== want.run_start) flag_mismatch("run_start", 32'(want.run_start),
                                                          32'(run_start_o));
        if (last_o !== want.is_last) flag_mismatch("last", 32'(want.is_last), 32'(last_o));
      end
    end
  end

  task automatic test_empty_flush();
    send_flush();
    send_flush();
  endtask

  task automatic test_quadrants();
    send_item(KindSet, 2'd3, 5'd0, 5'd0);
    send_item(KindSet, 2'd1, 5'd2, 5'd0);
    send_item(KindSet, 2'd2, 5'd0, 5'd2);
    send_item(KindSet, 2'd3, 5'd3, 5'd3);
    send_item(KindSet, 2'd2, 5'd4, 5'd1);
    send_item(KindSet, 2'd1, 5'd13, 5'd0);
    send_flush();
    send_flush();
  endtask

  // a run that ends on the final byte of the table
  task automatic test_final_byte_run();
    send_item(KindSet, 2'd1, 5'd31, 5'd31);
    send_item(KindSet, 2'd2, 5'd27, 5'd28);
    send_item(KindSet, 2'd3, 5'd28, 5'd28);
    send_flush();
  endtask

  task automatic test_fill();
    send_item(KindFill, 2'd2, 5'd31, 5'd31);
    send_item(KindSet, 2'd0, 5'd9, 5'd17);
    send_flush();
    send_item(KindSet, 2'd3, 5'd20, 5'd6);
    send_item(KindFill, 2'd1, 5'd0, 5'd0);
    send_flush();
  endtask

  task automatic test_unused_kind();
    send_item(KindUnused, 2'd3, 5'd31, 5'd31);
    send_flush();
  endtask

  task automatic test_base_extremes();
    wait_idle();
    write_base(14'h3FFF);
    send_item(KindSet, 2'd2, 5'd31, 5'd31);
    send_item(KindSet, 2'd1, 5'd0, 5'd0);
    send_flush();
    wait_idle();
    write_base('0);
    send_item(KindSet, 2'd3, 5'd17, 5'd9);
    send_flush();
  endtask

  // hold the output while a full-table flush and more items queue up
  task automatic test_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    hold_len = 300;
    send_item(KindFill, 2'($urandom), 5'($urandom), 5'($urandom));
    for (int i = 0; i < TableBytes; i++) set_byte(OffW'(i), 2'($urandom));
    send_flush();
    for (int i = 0; i < 8; i++) set_byte(OffW'($urandom), 2'($urandom));
    send_flush();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int unsigned     burst;
    int unsigned     pick;
    int unsigned     n;
    logic [OffW-1:0] start;
    burst = 0;
    while (items_sent < ItemTarget) begin
      if (burst % 6 == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       write_base('0);
          1:       write_base('1);
          2:       write_base(ResetBase);
          default: write_base(VAddrW'($urandom));
        endcase
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      burst++;
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        n = $urandom_range(1, 12);
        start = OffW'($urandom);
        for (int k = 0; k < n; k++) begin
          if (pick < 3) set_byte(OffW'(start + k), 2'($urandom));
          else send_item(KindSet, 2'($urandom), 5'($urandom), 5'($urandom));
        end
        send_flush();
      end else if (pick == 7) begin
        send_item(KindFill, 2'($urandom), 5'($urandom), 5'($urandom));
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) send_item(KindSet, 2'($urandom), 5'($urandom),
                                              5'($urandom));
        send_flush();
      end else if (pick == 8) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) send_item(2'($urandom), 2'($urandom), 5'($urandom),
                                              5'($urandom));
      end else begin
        send_flush();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    kind_i      = KindSet;
    color_i     = '0;
    tile_x_i    = '0;
    tile_y_i    = '0;
    mismatches  = 0;
    items_sent  = 0;
    hold_len    = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    vram_base   = ResetBase;
    dirty_bytes = '0;
    for (int i = 0; i < TableBytes; i++) shadow_bytes[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_flush();
    test_quadrants();
    test_final_byte_run();
    test_fill();
    test_unused_kind();
    test_base_extremes();
    test_backpressure();
    test_random_mix();

    wait_idle();
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
